// ===== src/deqr_pkg.sv =====
`default_nettype none

package deqr_pkg;

	localparam int FUNC_W     = 3;
	localparam int VAL_W      = 32;
	localparam int IDX_W      = 9;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 64;
	localparam int SCAN_GRP   = 16;

	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_FIND       = 3'd5;

	typedef struct packed {
		logic load;
		logic comp;
		logic scan;
		logic fin;
	} deqr_cmd_t;

	typedef struct packed {
		logic need_comp_in;
		logic need_scan;
		logic hit;
		logic scan_end;
		logic out_free;
	} deqr_sts_t;

	// packed MSB first, so status lands in bit 0 of the output word
	typedef struct packed {
		logic             is_full;
		logic             is_empty;
		logic [IDX_W-1:0] last_slot;
		logic [IDX_W-1:0] occupied_count;
		logic [IDX_W-1:0] found_index;
		logic [VAL_W-1:0] out_value;
		logic             status;
	} deqr_res_t;

	localparam int RES_W = $bits(deqr_res_t);

endpackage

`default_nettype wire

// ===== src/deqr_ctrl.sv =====
`default_nettype none

module deqr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  deqr_pkg::deqr_sts_t sts,
	output deqr_pkg::deqr_cmd_t cmd
);
	import deqr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COMP = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = sts.need_comp_in ? ST_COMP : ST_FIN;
				end
			end
			ST_COMP: begin
				cmd.comp = 1'b1;
				state_d  = sts.need_scan ? ST_SCAN : ST_FIN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.scan_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// commit only when the output register can take the result
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// ===== src/deqr_dp.sv =====
`default_nettype none

module deqr_dp #(
	parameter int DEPTH        = 256,
	parameter int HANDLE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  deqr_pkg::deqr_cmd_t          cmd,
	input  logic [deqr_pkg::FUNC_W-1:0]  in_func,
	input  logic [deqr_pkg::VAL_W-1:0]   in_value,
	input  logic                         out_ready,
	output deqr_pkg::deqr_sts_t          sts,
	output logic                         out_valid,
	output deqr_pkg::deqr_res_t          res
);
	import deqr_pkg::*;

	localparam int CW   = (HANDLE_WIDTH < VAL_W) ? HANDLE_WIDTH : VAL_W;
	localparam int IW   = $clog2(DEPTH);
	localparam int TW   = IW + 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam int NGRP = (DEPTH + SCAN_GRP - 1) / SCAN_GRP;
	localparam int MW   = NGRP * SCAN_GRP;
	localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int LW   = $clog2(SCAN_GRP);

	localparam logic [2:0] OP_HOLD = 3'd0;
	localparam logic [2:0] OP_UP   = 3'd1;
	localparam logic [2:0] OP_DN   = 3'd2;
	localparam logic [2:0] OP_WR   = 3'd3;
	localparam logic [2:0] OP_CLR  = 3'd4;

	logic [FUNC_W-1:0]    func_q;
	logic [CW-1:0]        val_q;
	logic [CW-1:0]        slot_q [DEPTH];
	logic [MW-1:0]        mt_q;
	logic [CW-1:0]        back_q;
	logic [GW-1:0]        grp_q;
	logic                 fnd_q;
	logic [IW-1:0]        fidx_q;
	logic signed [TW-1:0] top_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 out_valid_q;
	deqr_res_t            res_q;

	logic [MW-1:0]        match_w;
	logic [CW-1:0]        back_w;
	logic [LW-1:0]        loc_w;
	logic                 hit_w;
	logic [GW+LW-1:0]     fcat_w;

	logic                 full_w;
	logic                 none_w;
	logic                 val_ok;
	logic                 dec_ok;
	logic signed [TW-1:0] top_p1;
	logic signed [TW-1:0] top_m1;
	logic signed [TW-1:0] fidx_s;
	logic                 st_d;
	logic [CW-1:0]        outv_d;
	logic [CNTW-1:0]      cnt_d;
	logic signed [TW-1:0] top_d;
	logic [2:0]           op_d;
	logic [IW-1:0]        tgt_d;

	// parallel compare of every cell against the key
	always_comb begin
		match_w = '0;
		for (int i = 0; i < DEPTH; i++) begin
			match_w[i] = (slot_q[i] == val_q);
		end
	end

	// one-hot read of the back cell
	always_comb begin
		back_w = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (top_q == TW'(i)) begin
				back_w = back_w | slot_q[i];
			end
		end
	end

	// first match within the group at the bottom of the match word
	always_comb begin
		loc_w = '0;
		for (int j = SCAN_GRP - 1; j >= 0; j--) begin
			if (mt_q[j]) begin
				loc_w = LW'(j);
			end
		end
	end

	assign hit_w  = |mt_q[SCAN_GRP-1:0];
	assign fcat_w = {grp_q, loc_w};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			val_q  <= in_value[CW-1:0];
		end
		if (cmd.comp) begin
			mt_q   <= match_w;
			back_q <= back_w;
			grp_q  <= '0;
		end else if (cmd.scan && !hit_w) begin
			mt_q  <= mt_q >> SCAN_GRP;
			grp_q <= grp_q + GW'(1);
		end
		if (cmd.scan && hit_w) begin
			fidx_q <= fcat_w[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnd_q <= 1'b0;
		end else if (cmd.load) begin
			fnd_q <= 1'b0;
		end else if (cmd.scan && hit_w) begin
			fnd_q <= 1'b1;
		end
	end

	assign full_w = (top_q == TW'(DEPTH - 1));
	assign none_w = top_q[TW-1];
	assign val_ok = |val_q;
	assign dec_ok = (cnt_q != '0);
	assign top_p1 = top_q + TW'(1);
	assign top_m1 = top_q - TW'(1);
	assign fidx_s = $signed({1'b0, fidx_q});

	always_comb begin
		st_d   = 1'b1;
		outv_d = '0;
		cnt_d  = cnt_q;
		top_d  = top_q;
		op_d   = OP_HOLD;
		tgt_d  = '0;
		case (func_q)
			FN_PUSH_FRONT: begin
				if (!full_w && val_ok) begin
					op_d  = OP_UP;
					cnt_d = cnt_q + CNTW'(1);
					top_d = top_p1;
					st_d  = 1'b0;
				end
			end
			FN_PUSH_BACK: begin
				if (!full_w && val_ok) begin
					op_d  = OP_WR;
					tgt_d = top_p1[IW-1:0];
					cnt_d = cnt_q + CNTW'(1);
					top_d = top_p1;
					st_d  = 1'b0;
				end
			end
			FN_POP_FRONT: begin
				if (!none_w) begin
					outv_d = slot_q[0];
					if ((|slot_q[0]) && dec_ok) begin
						cnt_d = cnt_q - CNTW'(1);
					end
					op_d  = OP_DN;
					top_d = top_m1;
					st_d  = 1'b0;
				end
			end
			FN_POP_BACK: begin
				if (!none_w) begin
					outv_d = back_q;
					if ((|back_q) && dec_ok) begin
						cnt_d = cnt_q - CNTW'(1);
					end
					op_d  = OP_CLR;
					tgt_d = top_q[IW-1:0];
					top_d = top_m1;
					st_d  = 1'b0;
				end
			end
			FN_REMOVE: begin
				if (fnd_q) begin
					op_d  = OP_CLR;
					tgt_d = fidx_q;
					if (dec_ok) begin
						cnt_d = cnt_q - CNTW'(1);
					end
					// removing the back entry pulls the top down to just below it
					if (fidx_s >= top_q) begin
						top_d = fidx_s - TW'(1);
					end
					st_d = 1'b0;
				end
			end
			FN_FIND: begin
				st_d = !fnd_q;
			end
			default: begin
			end
		endcase
	end

	// cells above the top are always zero, so shifts move the whole row
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [CW-1:0] nb_lo;
			logic [CW-1:0] nb_hi;
			if (gi == 0) begin : g_lo_key
				assign nb_lo = val_q;
			end else begin : g_lo_cell
				assign nb_lo = slot_q[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_hi_zero
				assign nb_hi = '0;
			end else begin : g_hi_cell
				assign nb_hi = slot_q[gi+1];
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					slot_q[gi] <= '0;
				end else if (cmd.fin) begin
					case (op_d)
						OP_UP: begin
							slot_q[gi] <= nb_lo;
						end
						OP_DN: begin
							slot_q[gi] <= nb_hi;
						end
						OP_WR: begin
							if (tgt_d == IW'(gi)) begin
								slot_q[gi] <= val_q;
							end
						end
						OP_CLR: begin
							if (tgt_d == IW'(gi)) begin
								slot_q[gi] <= '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '1;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			top_q       <= top_d;
			cnt_q       <= cnt_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			res_q.status         <= st_d;
			res_q.out_value      <= VAL_W'(outv_d);
			res_q.found_index    <= fnd_q ? IDX_W'(fidx_q) : '1;
			res_q.occupied_count <= IDX_W'(cnt_d);
			res_q.last_slot      <= IDX_W'(top_d);
			res_q.is_empty       <= (cnt_d == '0);
			res_q.is_full        <= (top_d == TW'(DEPTH - 1));
		end
	end

	assign sts.need_comp_in = in_func inside {FN_POP_BACK, FN_REMOVE, FN_FIND};
	assign sts.need_scan    = (func_q inside {FN_REMOVE, FN_FIND}) && val_ok;
	assign sts.hit          = hit_w;
	assign sts.scan_end     = (grp_q == GW'(NGRP - 1));
	assign sts.out_free     = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== src/double_ended_queue_with_removal.sv =====
`default_nettype none

// Double-ended handle store: DEPTH register cells of handles (zero marks an empty
// cell), with a held count and the index of the highest cell in use. Each input
// transaction carries one operation (push front/back, pop front/back, remove value,
// find value) and yields exactly one output transaction with status, popped value,
// match index, count, top index and empty/full flags. Push front, push back, pop
// front and unused codes go from the input register straight to the commit step;
// pop back adds a step that reads the back cell. Remove and find compare all cells
// in parallel and then, for a nonzero value, scan the match bits 16 cells per
// cycle until the first 16-cell group with a match or the last group (at most
// ceil(DEPTH/16) groups). One operation is in flight at a time; the result sits
// in an output register, and the next operation is taken while it waits, but it
// cannot complete until the previous result has been taken. Reset clears all
// cells at once; no clearing pass is needed.
module double_ended_queue_with_removal #(
	parameter int DEPTH        = 256,
	parameter int HANDLE_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// func[2:0], item_value[34:3], zero pad
	input  logic [deqr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// status[0], out_value[32:1], found_index[41:33], occupied_count[50:42],
	// last_slot[59:51], is_empty[60], is_full[61], zero pad
	output logic [deqr_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import deqr_pkg::*;

	deqr_cmd_t cmd;
	deqr_sts_t sts;
	deqr_res_t res;

	deqr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	deqr_dp #(
		.DEPTH        (DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_func   (s_axis_tdata[FUNC_W-1:0]),
		.in_value  (s_axis_tdata[FUNC_W+VAL_W-1:FUNC_W]),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.res       (res)
	);

	assign m_axis_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, res};

endmodule

`default_nettype wire

// ===== src/deqr_chk.sv =====
`default_nettype none

module deqr_chk (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_axis_tvalid,
	input wire                            s_axis_tready,
	input wire                            m_axis_tvalid,
	input wire                            m_axis_tready,
	input wire [deqr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import deqr_pkg::*;

	logic in_xact;
	assign in_xact = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> !s_axis_tready)
		else $error("input taken while an operation is in flight");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared one cycle after input transaction");

	a_reject_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[VAL_W:1] == '0)
		else $error("rejected operation returned a handle");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:RES_W] == '0)
		else $error("output pad bits not zero");

endmodule

bind double_ended_queue_with_removal deqr_chk u_deqr_chk (.*);

`default_nettype wire
